// File: hw/rtl/ott_pkg.sv
package ott_pkg;

    // Input item
    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_expr;
    } t_in;

    // Result item
    typedef struct packed {
        logic [3:0]  token_kind;
        logic [15:0] token_pos;
        logic [15:0] token_len;
        logic [7:0]  nest_depth;
        logic [3:0]  operator_slot;
        logic        run_last;
    } t_out;

    // Operator search result
    typedef struct packed {
        logic       hit;
        logic [3:0] slot;
        logic [3:0] len;
    } t_match;

    localparam logic [3:0] KIND_OP    = 4'd0;
    localparam logic [3:0] KIND_STR   = 4'd1;
    localparam logic [3:0] KIND_IDENT = 4'd2;
    localparam logic [3:0] KIND_NUM   = 4'd3;
    localparam logic [3:0] KIND_OPAR  = 4'd4;
    localparam logic [3:0] KIND_OBRK  = 4'd5;
    localparam logic [3:0] KIND_OBRC  = 4'd6;
    localparam logic [3:0] KIND_CPAR  = 4'd7;
    localparam logic [3:0] KIND_CBRK  = 4'd8;
    localparam logic [3:0] KIND_CBRC  = 4'd9;

    localparam logic [3:0] NO_SLOT = 4'd8;
    localparam logic [3:0] MAX_RES = 4'd10;

    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_STR   = 2'd1;
    localparam logic [1:0] MODE_IDENT = 2'd2;
    localparam logic [1:0] MODE_NUM   = 2'd3;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_OPAR  = 8'h28;
    localparam logic [7:0] CH_OBRK  = 8'h5B;
    localparam logic [7:0] CH_OBRC  = 8'h7B;
    localparam logic [7:0] CH_CPAR  = 8'h29;
    localparam logic [7:0] CH_CBRK  = 8'h5D;
    localparam logic [7:0] CH_CBRC  = 8'h7D;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

endpackage

// File: hw/rtl/operator_table_tokenizer.sv
// Channel | Signals                               | Transfer when
// --------+---------------------------------------+-------------------------
// in      | i_in_valid, o_in_stall, i_in_data     | i_in_valid & !o_in_stall
// out     | o_out_valid, i_out_stall, o_out_data  | o_out_valid & !i_out_stall
// cfg     | i_cfg_we, i_cfg_idx, i_cfg_data       | i_cfg_we
//
// A character is first loaded into the window. Then come the window actions
// (each consumed character, each token end), a step to close the item (with
// the pending run out at the end of an expression) and a step to release the
// last token; the input stalls until then. The window is a row of cells that
// shift by one character per cycle while characters are consumed, unless a
// stalled output holds them.
// Synchronous active-low reset clears control state and operator registers.
// A stalled output holds the engine only when a token has nowhere to go.
module operator_table_tokenizer #(
    parameter int NUM_OPS    = 8,
    parameter int MAX_OP_LEN = 8,
    parameter int POS_BITS   = 16,
    parameter int DEPTH_BITS = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  ott_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output ott_pkg::t_out o_out_data,
    input  logic          i_cfg_we,
    input  logic [3:0]    i_cfg_idx,
    input  logic [63:0]   i_cfg_data
);
    import ott_pkg::*;

    localparam int WIN = MAX_OP_LEN + 1;
    localparam int FW  = $clog2(WIN + 1);
    localparam logic [POS_BITS-1:0] POS_MAX = '1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [NUM_OPS-1:0][63:0] r_op;
    logic [1:0]               r_state, n_state;
    logic                     r_flush, n_flush;
    logic [FW-1:0]            r_fill, n_fill;
    logic [FW-1:0]            r_skip, n_skip;
    logic [POS_BITS-1:0]      r_pos, n_pos;
    logic [POS_BITS-1:0]      r_run_start, n_run_start;
    logic [POS_BITS-1:0]      r_run_len, n_run_len;
    logic [DEPTH_BITS-1:0]    r_depth, n_depth;
    logic [1:0]               r_mode, n_mode;
    logic [3:0]               r_cnt;
    t_out                     r_hold;
    logic                     r_hold_vld;
    t_out                     r_out;
    logic                     r_out_vld;

    logic [WIN-1:0][7:0]         win_byte;
    logic [WIN-1:0][NUM_OPS-1:0] win_eq;
    logic [WIN-1:0]              win_space;
    t_match                      match;

    logic                  accept, out_free, any_op, out_load;
    logic                  active, shift, load, emit_req, emit_take, commit;
    logic [3:0]            e_kind;
    logic [POS_BITS-1:0]   e_pos, e_len;
    logic [DEPTH_BITS-1:0] e_depth;
    logic [3:0]            e_slot;
    t_out                  tok;
    t_out                  last_tok;
    logic [7:0]            c;

    function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
        return (v == POS_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic [15:0] clamp16(input logic [POS_BITS-1:0] v);
        logic [POS_BITS-1:0] hi;
        hi = v >> 16;
        return (hi != '0) ? 16'hFFFF : 16'(v);
    endfunction

    // Lookahead window cells
    for (genvar j = 0; j < WIN; j++) begin : g_cell
        logic [NUM_OPS-1:0][7:0] op_col;
        logic [7:0]              next_byte;
        always_comb begin
            for (int i = 0; i < NUM_OPS; i++) begin
                op_col[i] = (j < MAX_OP_LEN) ? r_op[i][8*(j % MAX_OP_LEN) +: 8] : 8'h00;
            end
        end
        if (j == WIN - 1) begin : g_tail
            assign next_byte = 8'h00;
        end else begin : g_link
            assign next_byte = win_byte[j+1];
        end
        ott_cell #(
            .NUM_OPS(NUM_OPS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_load     (load && r_fill == FW'(j)),
            .i_load_byte(i_in_data.char_code),
            .i_shift    (shift && commit),
            .i_next_byte(next_byte),
            .i_op_col   (op_col),
            .o_byte     (win_byte[j]),
            .o_eq       (win_eq[j]),
            .o_space    (win_space[j])
        );
    end

    ott_match #(
        .NUM_OPS   (NUM_OPS),
        .MAX_OP_LEN(MAX_OP_LEN),
        .FW        (FW)
    ) u_match (
        .i_op   (r_op),
        .i_eq   (win_eq),
        .i_space(win_space),
        .i_fill (r_fill),
        .o_match(match)
    );

    assign o_in_stall  = (r_state != ST_IDLE);
    assign accept      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_vld || !i_out_stall;
    assign any_op      = |r_op;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;
    assign c           = win_byte[0];
    assign active      = (r_skip != '0) ||
                         (r_fill != '0 && (r_flush || r_fill == FW'(WIN)));

    // Window action for this cycle
    always_comb begin
        n_state     = r_state;
        n_flush     = r_flush;
        n_fill      = r_fill;
        n_skip      = r_skip;
        n_pos       = r_pos;
        n_run_start = r_run_start;
        n_run_len   = r_run_len;
        n_depth     = r_depth;
        n_mode      = r_mode;
        shift       = 1'b0;
        load        = 1'b0;
        emit_req    = 1'b0;
        e_kind      = KIND_OP;
        e_pos       = r_pos;
        e_len       = '0;
        e_depth     = r_depth;
        e_slot      = NO_SLOT;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    load    = 1'b1;
                    n_fill  = r_fill + 1'b1;
                    n_flush = i_in_data.end_of_expr;
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (active) begin
                    if (r_skip != '0) begin
                        shift  = 1'b1;
                        n_skip = r_skip - 1'b1;
                    end else begin
                        case (r_mode)
                            MODE_STR: begin
                                if (c == CH_QUOTE) begin
                                    if (r_run_len != '0) begin
                                        emit_req = 1'b1;
                                        e_kind   = KIND_STR;
                                        e_pos    = r_run_start;
                                        e_len    = r_run_len;
                                        shift    = 1'b1;
                                    end
                                    n_mode = MODE_IDLE;
                                end else begin
                                    n_run_len = sat_inc(r_run_len);
                                    shift     = 1'b1;
                                end
                            end
                            MODE_IDENT, MODE_NUM: begin
                                if ((r_mode == MODE_IDENT) ?
                                        (is_alpha(c) || is_digit(c) || c == CH_UNDER) :
                                        (is_digit(c) || c == CH_DOT)) begin
                                    n_run_len = sat_inc(r_run_len);
                                    shift     = 1'b1;
                                end else begin
                                    emit_req = 1'b1;
                                    e_kind   = (r_mode == MODE_IDENT) ? KIND_IDENT : KIND_NUM;
                                    e_pos    = r_run_start;
                                    e_len    = r_run_len;
                                    n_mode   = MODE_IDLE;
                                end
                            end
                            default: begin
                                shift = 1'b1;
                                if (match.hit) begin
                                    emit_req = 1'b1;
                                    e_kind   = KIND_OP;
                                    e_len    = POS_BITS'(match.len);
                                    e_slot   = match.slot;
                                    n_skip   = FW'(match.len - 4'd1);
                                end else if (c == CH_QUOTE) begin
                                    n_mode      = MODE_STR;
                                    n_run_start = sat_inc(r_pos);
                                    n_run_len   = '0;
                                end else if (is_alpha(c) || is_digit(c) || c == CH_UNDER) begin
                                    n_mode      = is_digit(c) ? MODE_NUM : MODE_IDENT;
                                    n_run_start = r_pos;
                                    n_run_len   = POS_BITS'(1);
                                end else if (c == CH_OPAR || c == CH_OBRK || c == CH_OBRC) begin
                                    emit_req = 1'b1;
                                    e_kind   = (c == CH_OPAR) ? KIND_OPAR :
                                               ((c == CH_OBRK) ? KIND_OBRK : KIND_OBRC);
                                    e_len    = POS_BITS'(1);
                                    n_depth  = r_depth + 1'b1;
                                end else if (c == CH_CPAR || c == CH_CBRK || c == CH_CBRC) begin
                                    emit_req = 1'b1;
                                    e_kind   = (c == CH_CPAR) ? KIND_CPAR :
                                               ((c == CH_CBRK) ? KIND_CBRK : KIND_CBRC);
                                    e_len    = POS_BITS'(1);
                                    n_depth  = r_depth - 1'b1;
                                    e_depth  = r_depth - 1'b1;
                                end
                            end
                        endcase
                    end
                    if (shift) begin
                        n_fill = r_fill - 1'b1;
                        n_pos  = sat_inc(r_pos);
                    end
                end else begin
                    // Close item; on flush: pending run out, state back to start
                    if (r_flush) begin
                        if (r_mode == MODE_IDENT || r_mode == MODE_NUM ||
                                (r_mode == MODE_STR && r_run_len != '0)) begin
                            emit_req = 1'b1;
                            e_kind   = (r_mode == MODE_IDENT) ? KIND_IDENT :
                                       ((r_mode == MODE_NUM) ? KIND_NUM : KIND_STR);
                            e_pos    = r_run_start;
                            e_len    = r_run_len;
                        end
                        n_mode      = MODE_IDLE;
                        n_fill      = '0;
                        n_pos       = '0;
                        n_depth     = '0;
                        n_run_start = '0;
                        n_run_len   = '0;
                        n_flush     = 1'b0;
                    end
                    n_state = ST_DONE;
                end
            end
            default: begin
            end
        endcase
    end

    assign emit_take = emit_req && any_op && (r_cnt < MAX_RES);
    assign commit    = !(emit_take && r_hold_vld && !out_free);
    assign out_load  = (r_state == ST_DONE) ? (r_hold_vld && out_free) :
                       (r_state == ST_RUN && commit && emit_take && r_hold_vld);

    // Token in result form
    always_comb begin
        tok.token_kind    = e_kind;
        tok.token_pos     = clamp16(e_pos);
        tok.token_len     = clamp16(e_len);
        tok.nest_depth    = 8'(e_depth);
        tok.operator_slot = e_slot;
        tok.run_last      = 1'b0;
    end

    // Held token marked as the last of this item
    always_comb begin
        last_tok          = r_hold;
        last_tok.run_last = 1'b1;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op        <= '0;
            r_state     <= ST_IDLE;
            r_flush     <= 1'b0;
            r_fill      <= '0;
            r_skip      <= '0;
            r_pos       <= '0;
            r_run_start <= '0;
            r_run_len   <= '0;
            r_depth     <= '0;
            r_mode      <= MODE_IDLE;
            r_cnt       <= '0;
            r_hold_vld  <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            // Write operator registers
            for (int i = 0; i < NUM_OPS; i++) begin
                if (i_cfg_we && i_cfg_idx == 4'(i)) begin
                    r_op[i] <= i_cfg_data;
                end
            end
            // Raise a newly loaded result, drop a transferred one
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && !i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            if (r_state == ST_DONE) begin
                // Release the held token as the last of this item
                if (!r_hold_vld) begin
                    r_state <= ST_IDLE;
                end else if (out_free) begin
                    r_hold_vld <= 1'b0;
                    r_state    <= ST_IDLE;
                end
            end else if (commit) begin
                r_state     <= n_state;
                r_flush     <= n_flush;
                r_fill      <= n_fill;
                r_skip      <= n_skip;
                r_pos       <= n_pos;
                r_run_start <= n_run_start;
                r_run_len   <= n_run_len;
                r_depth     <= n_depth;
                r_mode      <= n_mode;
                if (accept) begin
                    r_cnt <= '0;
                end
                if (r_state == ST_RUN && emit_take) begin
                    r_cnt      <= r_cnt + 1'b1;
                    r_hold_vld <= 1'b1;
                end
            end
        end
    end

    // Token payloads
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= (r_state == ST_DONE) ? last_tok : r_hold;
        end
        if (r_state == ST_RUN && commit && emit_take) begin
            r_hold <= tok;
        end
    end

endmodule

// File: hw/rtl/ott_cell.sv
module ott_cell #(
    parameter int NUM_OPS = 8
) (
    input  logic                     i_clk,
    input  logic                     i_load,
    input  logic [7:0]               i_load_byte,
    input  logic                     i_shift,
    input  logic [7:0]               i_next_byte,
    input  logic [NUM_OPS-1:0][7:0]  i_op_col,
    output logic [7:0]               o_byte,
    output logic [NUM_OPS-1:0]       o_eq,
    output logic                     o_space
);
    import ott_pkg::*;

    logic [7:0] r_byte;

    // Take a new character or the neighbor's on a shift
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_byte <= i_load_byte;
        end else if (i_shift) begin
            r_byte <= i_next_byte;
        end
    end

    // Compare against this column of every operator
    always_comb begin
        for (int i = 0; i < NUM_OPS; i++) begin
            o_eq[i] = (r_byte == i_op_col[i]);
        end
    end

    assign o_byte  = r_byte;
    assign o_space = is_space(r_byte);

endmodule

// File: hw/rtl/ott_match.sv
module ott_match #(
    parameter int NUM_OPS    = 8,
    parameter int MAX_OP_LEN = 8,
    parameter int FW         = 4
) (
    input  logic [NUM_OPS-1:0][63:0]            i_op,
    input  logic [MAX_OP_LEN:0][NUM_OPS-1:0]    i_eq,
    input  logic [MAX_OP_LEN:0]                 i_space,
    input  logic [FW-1:0]                       i_fill,
    output ott_pkg::t_match                     o_match
);
    import ott_pkg::*;

    logic [NUM_OPS-1:0][3:0] op_len;
    logic [NUM_OPS-1:0]      op_ok;

    // Operator length and fit at the window head
    always_comb begin
        logic       run;
        logic [7:0] last;
        for (int i = 0; i < NUM_OPS; i++) begin
            op_len[i] = '0;
            run = 1'b1;
            for (int j = 0; j < MAX_OP_LEN; j++) begin
                if (run && i_op[i][8*j +: 8] != 8'h00) begin
                    op_len[i] = 4'(j + 1);
                end else begin
                    run = 1'b0;
                end
            end
            op_ok[i] = (op_len[i] != 4'd0) && (FW'(op_len[i]) <= i_fill);
            for (int j = 0; j < MAX_OP_LEN; j++) begin
                if (4'(j) < op_len[i] && !i_eq[j][i]) begin
                    op_ok[i] = 1'b0;
                end
            end
            last = 8'h00;
            for (int j = 0; j < MAX_OP_LEN; j++) begin
                if (4'(j + 1) == op_len[i]) begin
                    last = i_op[i][8*j +: 8];
                end
            end
            // Alphanumeric tail needs whitespace or the end after it
            for (int j = 0; j <= MAX_OP_LEN; j++) begin
                if (4'(j) == op_len[i] && FW'(op_len[i]) < i_fill && !i_space[j]
                        && (is_alpha(last) || is_digit(last))) begin
                    op_ok[i] = 1'b0;
                end
            end
        end
    end

    // Longest wins, lowest slot on a tie
    always_comb begin
        o_match.hit  = 1'b0;
        o_match.slot = NO_SLOT;
        o_match.len  = '0;
        for (int i = 0; i < NUM_OPS; i++) begin
            if (op_ok[i] && op_len[i] > o_match.len) begin
                o_match.hit  = 1'b1;
                o_match.slot = 4'(i);
                o_match.len  = op_len[i];
            end
        end
    end

endmodule
